@@ rtl/ifmt_pkg.sv @@
`default_nettype none

package ifmt_pkg;

    // ASCII codes used in the text field.
    localparam logic [7:0] CHAR_BLANK = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    // Largest magnitude 2^31 has ten decimal digits.
    localparam int NUM_DIGITS = 10;

    // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x.
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // Depth of the queue between the digit front end and the character back end.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        FILL_NUM,
        FILL_BLANK,
        FILL_STAR
    } fill_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_MUL,
        FS_SUB,
        FS_CLASS
    } front_state_t;

    // One classified field, ready to be spelled out character by character.
    typedef struct packed {
        fill_t            fill;
        logic [6:0]       width;
        logic [6:0]       need;
        logic [3:0]       len;
        logic             sign;
        logic             neg;
        logic [9:0][3:0]  digits;
    } desc_t;

endpackage

`default_nettype wire

@@ rtl/integer_field_formatter.sv @@
`default_nettype none

// Integer field formatter: turns a signed 32-bit value into a right-justified
// decimal text field, one ASCII character per result transfer.
// Input channel: a transfer happens on a clock edge with push high and full low;
// value, field_width and min_digits travel together. A field width of zero
// produces no characters; widths above MAX_WIDTH are clipped to MAX_WIDTH.
// Result channel: while empty is low, text_char and last_char show the oldest
// character; pop high on that edge completes the transfer. last_char marks the
// rightmost character of each field.
// Config channel: cfg_data (plus_mode) is written on an edge with cfg_valid and
// cfg_ready high; cfg_ready is always high. Write it only while the block is idle.
// The front end extracts each decimal digit with a reciprocal multiply and then
// a remainder step, then classifies the field; an all-blank field skips the
// digit steps and a zero-width item is taken in the idle state and produces nothing.
// The back end emits one character per cycle while pop keeps up, after loading each
// field from the queue. A two-entry queue between them lets both run at once, so
// the sustained rate is set by the slower of the two.
// Reset clears all control state and plus_mode; no memory needs clearing.
// When the receiver holds pop low, the output register holds, the back end
// stops, the queue fills and then full rises on the input side.
module integer_field_formatter #(
    parameter int MAX_WIDTH = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic signed [31:0]  value,
    input  wire logic [6:0]          field_width,
    input  wire logic [6:0]          min_digits,
    output logic                     empty,
    input  wire logic                pop,
    output logic [7:0]               text_char,
    output logic                     last_char,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_data
);

    logic            plus_mode_reg;

    logic            q_push;
    ifmt_pkg::desc_t q_wr_data;
    logic            q_full;
    logic            q_pop;
    ifmt_pkg::desc_t q_rd_data;
    logic            q_empty;

    // The single configuration register is always writable.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            plus_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready) begin
            plus_mode_reg <= cfg_data;
        end
    end

    // Front end: takes items, extracts digits and classifies the field.
    ifmt_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .value       (value),
        .field_width (field_width),
        .min_digits  (min_digits),
        .plus_mode   (plus_mode_reg),
        .q_push      (q_push),
        .q_data      (q_wr_data),
        .q_full      (q_full)
    );

    // Queue of classified fields so the two ends can stall independently.
    ifmt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .q_empty (q_empty)
    );

    // Back end: emits one character per cycle through its output register while the receiver keeps popping.
    ifmt_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (q_rd_data),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .text_char (text_char),
        .last_char (last_char)
    );

endmodule

`default_nettype wire

@@ rtl/ifmt_front.sv @@
`default_nettype none

// Accepts an item, extracts its decimal digits with a multiply step and a remainder step each and
// classifies the field as blank, asterisks or a number.
module ifmt_front #(
    parameter int MAX_WIDTH = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic signed [31:0]   value,
    input  wire logic [6:0]           field_width,
    input  wire logic [6:0]           min_digits,
    input  wire logic                 plus_mode,
    output logic                      q_push,
    output ifmt_pkg::desc_t           q_data,
    input  wire logic                 q_full
);

    localparam logic [6:0] MAX_W = 7'(MAX_WIDTH);

    ifmt_pkg::front_state_t state_reg, state_next;
    logic [3:0]             len_reg, len_next;

    logic [31:0]            mag_reg;
    logic                   neg_reg;
    logic [6:0]             width_reg;
    logic [6:0]             mind_reg;
    logic                   zero_reg;
    logic [63:0]            prod_reg;
    logic [9:0][3:0]        digits_reg;

    logic [6:0]             width_sat;
    logic [28:0]            quot;
    logic [31:0]            quot_x10;
    logic [31:0]            rem_full;
    logic [6:0]             need;
    logic                   sign;

    assign width_sat = (field_width > MAX_W) ? MAX_W : field_width;
    assign quot      = prod_reg[63:ifmt_pkg::RECIP_SHIFT];
    assign quot_x10  = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign rem_full  = mag_reg - quot_x10;
    assign need      = (mind_reg > {3'b000, len_reg}) ? mind_reg : {3'b000, len_reg};
    assign sign      = neg_reg | plus_mode;
    assign full      = (state_reg != ifmt_pkg::FS_IDLE);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ifmt_pkg::FS_IDLE;
            len_reg   <= 4'd0;
        end
        else begin
            state_reg <= state_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk) begin
        case (state_reg)
            ifmt_pkg::FS_IDLE:
            begin
                mag_reg   <= value[31] ? (32'd0 - value) : value;
                neg_reg   <= value[31];
                width_reg <= width_sat;
                mind_reg  <= min_digits;
                zero_reg  <= (value == 32'sd0) && (min_digits == 7'd0);
            end
            ifmt_pkg::FS_MUL:
            begin
                prod_reg <= 64'(mag_reg) * 64'(ifmt_pkg::RECIP_10);
            end
            ifmt_pkg::FS_SUB:
            begin
                digits_reg[len_reg] <= rem_full[3:0];
                mag_reg             <= {3'b000, quot};
            end
            default:
            begin
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        q_push       = 1'b0;
        q_data.width = width_reg;
        q_data.need  = need;
        q_data.len   = len_reg;
        q_data.sign  = sign;
        q_data.neg   = neg_reg;
        q_data.digits = digits_reg;
        if (zero_reg) begin
            q_data.fill = ifmt_pkg::FILL_BLANK;
        end
        else if ((need > width_reg) || (sign && (need == width_reg))) begin
            q_data.fill = ifmt_pkg::FILL_STAR;
        end
        else begin
            q_data.fill = ifmt_pkg::FILL_NUM;
        end

        case (state_reg)
            ifmt_pkg::FS_IDLE:
            begin
                len_next = 4'd0;
                if (push && (width_sat != 7'd0)) begin
                    if ((value == 32'sd0) && (min_digits == 7'd0)) begin
                        state_next = ifmt_pkg::FS_CLASS;
                    end
                    else begin
                        state_next = ifmt_pkg::FS_MUL;
                    end
                end
            end
            ifmt_pkg::FS_MUL:
            begin
                state_next = ifmt_pkg::FS_SUB;
            end
            ifmt_pkg::FS_SUB:
            begin
                len_next = len_reg + 4'd1;
                if ((quot == 29'd0) || (len_reg == 4'(ifmt_pkg::NUM_DIGITS - 1))) begin
                    state_next = ifmt_pkg::FS_CLASS;
                end
                else begin
                    state_next = ifmt_pkg::FS_MUL;
                end
            end
            ifmt_pkg::FS_CLASS:
            begin
                if (!q_full) begin
                    q_push     = 1'b1;
                    state_next = ifmt_pkg::FS_IDLE;
                end
            end
            default:
            begin
                state_next = ifmt_pkg::FS_IDLE;
            end
        endcase
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ifmt_pkg::FS_SUB) |-> (len_reg < 4'(ifmt_pkg::NUM_DIGITS)))
        else $error("digit count overran the digit buffer");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("descriptor pushed into a full queue");

    a_mag_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ifmt_pkg::FS_MUL) |-> ((mag_reg != 32'd0) || (len_reg == 4'd0)))
        else $error("digit loop continued past a zero quotient");

endmodule

`default_nettype wire

@@ rtl/ifmt_queue.sv @@
`default_nettype none

// Short queue of classified fields between the front and back ends.
module ifmt_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire ifmt_pkg::desc_t  wr_data,
    output logic                  q_full,
    input  wire logic             rd_en,
    output ifmt_pkg::desc_t       rd_data,
    output logic                  q_empty
);

    localparam int DEPTH = ifmt_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    ifmt_pkg::desc_t mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign q_full  = (count_reg == CW'(DEPTH));
    assign q_empty = (count_reg == CW'(0));
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (wr_en) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (rd_en) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (wr_en && !rd_en) begin
                count_reg <= count_reg + CW'(1);
            end
            else if (rd_en && !wr_en) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count exceeds its depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !q_full)
        else $error("write into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !q_empty)
        else $error("read from an empty queue");

endmodule

`default_nettype wire

@@ rtl/ifmt_back.sv @@
`default_nettype none

// Spells a classified field out one character per cycle into an output register while it is popped.
module ifmt_back #(
    parameter int MAX_WIDTH = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ifmt_pkg::desc_t  q_data,
    input  wire logic             q_empty,
    output logic                  q_pop,
    output logic                  empty,
    input  wire logic             pop,
    output logic [7:0]            text_char,
    output logic                  last_char
);

    localparam int RW = $clog2(MAX_WIDTH);

    ifmt_pkg::desc_t desc_reg;
    logic            busy_reg, busy_next;
    logic [RW-1:0]   pos_reg, pos_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      char_reg;
    logic            last_reg;

    logic            advance;
    logic [6:0]      pos_ext;
    logic [7:0]      char_now;

    // pos_reg counts character places from the right end of the field.
    assign pos_ext   = 7'(pos_reg);
    assign advance   = !out_valid_reg || pop;
    assign empty     = !out_valid_reg;
    assign text_char = char_reg;
    assign last_char = last_reg;

    always_comb begin
        case (desc_reg.fill)
            ifmt_pkg::FILL_STAR:  char_now = ifmt_pkg::CHAR_STAR;
            ifmt_pkg::FILL_BLANK: char_now = ifmt_pkg::CHAR_BLANK;
            ifmt_pkg::FILL_NUM:
            begin
                if (pos_ext < {3'b000, desc_reg.len}) begin
                    char_now = ifmt_pkg::CHAR_ZERO + {4'b0000, desc_reg.digits[pos_reg[3:0]]};
                end
                else if (pos_ext < desc_reg.need) begin
                    char_now = ifmt_pkg::CHAR_ZERO;
                end
                else if (desc_reg.sign && (pos_ext == desc_reg.need)) begin
                    char_now = desc_reg.neg ? ifmt_pkg::CHAR_MINUS : ifmt_pkg::CHAR_PLUS;
                end
                else begin
                    char_now = ifmt_pkg::CHAR_BLANK;
                end
            end
            default:              char_now = ifmt_pkg::CHAR_STAR;
        endcase
    end

    always_comb begin
        busy_next      = busy_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        q_pop          = 1'b0;
        if (advance) begin
            out_valid_next = busy_reg;
            if (busy_reg) begin
                if (pos_reg == '0) begin
                    busy_next = 1'b0;
                end
                else begin
                    pos_next = pos_reg - RW'(1);
                end
            end
            else if (!q_empty) begin
                q_pop     = 1'b1;
                busy_next = 1'b1;
                pos_next  = RW'(q_data.width - 7'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (q_pop) begin
            desc_reg <= q_data;
        end
        if (advance && busy_reg) begin
            char_reg <= char_now;
            last_reg <= (pos_reg == '0);
        end
    end

    a_pos_in_field: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pos_ext < desc_reg.width))
        else $error("character position outside the field");

    a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !busy_reg)
        else $error("new field taken while one is still being spelled");

    a_last_ends_field: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && busy_reg && (pos_reg == '0)) |=> (!busy_reg && last_reg))
        else $error("field end not marked on its last character");

endmodule

`default_nettype wire

@@ dv/ifmt_text_checker.sv @@
`default_nettype none

// Watches the input, result and config channels of the integer field formatter,
// predicts the text of every accepted field and compares each result transfer.
module ifmt_text_checker #(
    parameter int MAX_WIDTH = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic               full,
    input  wire logic signed [31:0] value,
    input  wire logic [6:0]         field_width,
    input  wire logic [6:0]         min_digits,
    input  wire logic               empty,
    input  wire logic               pop,
    input  wire logic [7:0]         text_char,
    input  wire logic               last_char,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic               cfg_data,
    output int                      fail_count,
    output int                      chars_pending
);

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } text_entry_t;

    text_entry_t expected_text[$];
    text_entry_t head;
    logic        plus_mode;

    // Spell out one field and queue its characters, leftmost first.
    function automatic void format_field(logic [31:0] raw, logic [6:0] fw, logic [6:0] md);
        logic [7:0]  chars[MAX_WIDTH];
        logic [3:0]  digit_list[10];
        logic [31:0] mag;
        logic        neg;
        logic        sign;
        int          width;
        int          len;
        int          need;
        int          space;
        int          pos;
        int          i;
        text_entry_t item;

        width = (int'(fw) > MAX_WIDTH) ? MAX_WIDTH : int'(fw);
        if (width == 0)
            return;
        pos = 0;
        if (raw == 0 && md == 0)
        begin
            for (i = 0; i < width; i++)
                chars[pos++] = ifmt_pkg::CHAR_BLANK;
        end
        else
        begin
            neg = raw[31];
            mag = neg ? (32'd0 - raw) : raw;
            len = 0;
            do
            begin
                digit_list[len] = 4'(mag % 10);
                len++;
                mag = mag / 10;
            end while (mag != 0 && len < 10);
            need = (int'(md) > len) ? int'(md) : len;
            sign = neg || plus_mode;
            if (need > width || (sign && need == width))
            begin
                for (i = 0; i < width; i++)
                    chars[pos++] = ifmt_pkg::CHAR_STAR;
            end
            else
            begin
                space = width - need - (sign ? 1 : 0);
                for (i = 0; i < space; i++)
                    chars[pos++] = ifmt_pkg::CHAR_BLANK;
                if (sign)
                    chars[pos++] = neg ? ifmt_pkg::CHAR_MINUS : ifmt_pkg::CHAR_PLUS;
                for (i = len; i < need; i++)
                    chars[pos++] = ifmt_pkg::CHAR_ZERO;
                for (i = len; i > 0; i--)
                    chars[pos++] = ifmt_pkg::CHAR_ZERO + {4'b0000, digit_list[i - 1]};
            end
        end
        for (i = 0; i < pos; i++)
        begin
            item.code = chars[i];
            item.last = (i == pos - 1);
            expected_text.push_back(item);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plus_mode     = 1'b0;
            fail_count    = 0;
            chars_pending = 0;
            expected_text.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_text.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected character: text_char %h last_char %b",
                                 text_char, last_char);
                end
                else
                begin
                    head = expected_text.pop_front();
                    if (head.code !== text_char || head.last !== last_char)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("text mismatch: expected %h/%b, got %h/%b",
                                     head.code, head.last, text_char, last_char);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                plus_mode = cfg_data;
            if (push && !full)
                format_field(value, field_width, min_digits);
            chars_pending = expected_text.size();
        end
    end

endmodule

`default_nettype wire

@@ dv/tb_integer_field_formatter.sv @@
`default_nettype none

// Top of the formatter testbench. It only makes stimulus and gives the verdict;
// the checker instance beside the block predicts and compares every transfer.
module tb_integer_field_formatter;

    localparam int FIELD_MAX    = 64;
    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 11;
    // The limit lies far above the slowest correct run: every field at 64 characters,
    // a receiver that pops one cycle in four, one long hold and the sender gaps.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    // A short pause after the last character before plus_mode is written again.
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 15;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic signed [31:0] value = '0;
    logic [6:0]         field_width = '0;
    logic [6:0]         min_digits = '0;
    logic               pop = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_data = 1'b0;
    logic               full;
    logic               empty;
    logic [7:0]         text_char;
    logic               last_char;
    logic               cfg_ready;
    int                 fail_count;
    int                 chars_pending;
    int                 cycle_count = 0;

    // The stimulus asks for one long receiver hold; the receiver notes that it took it.
    logic               hold_request = 1'b0;
    logic               hold_taken = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    integer_field_formatter #(
        .MAX_WIDTH(FIELD_MAX)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .value      (value),
        .field_width(field_width),
        .min_digits (min_digits),
        .empty      (empty),
        .pop        (pop),
        .text_char  (text_char),
        .last_char  (last_char),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    ifmt_text_checker #(
        .MAX_WIDTH(FIELD_MAX)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .value        (value),
        .field_width  (field_width),
        .min_digits   (min_digits),
        .empty        (empty),
        .pop          (pop),
        .text_char    (text_char),
        .last_char    (last_char),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .chars_pending(chars_pending)
    );

    // A hung block or a lost character ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offers one field and returns at the falling edge after its transfer, with
    // push still high so that a following item can go out back to back.
    task automatic send_item(input logic signed [31:0] val, input logic [6:0] fw,
                             input logic [6:0] md);
        value       = val;
        field_width = fw;
        min_digits  = md;
        push        = 1'b1;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
    endtask

    // Writes plus_mode; only called while the block is idle.
    task automatic write_plus_mode(input logic mode);
        cfg_data  = mode;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Stops offering fields until every predicted character has been
    // transferred, then waits a little longer with the block idle.
    task automatic drain_block();
        push = 1'b0;
        while (chars_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Random fields in bursts of random length. Most fields are narrow; a few are wide,
    // up to the full width, a few are oversized and a few have zero width.
    task automatic random_items(input int count);
        logic signed [31:0] val;
        logic [6:0]         fw;
        logic [6:0]         md;
        int                 sent;
        int                 burst;
        int                 k;

        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 8);
            for (k = 0; k < burst && sent < count; k++)
            begin
                case ($urandom_range(0, 5))
                    0, 1: val = $urandom;
                    2:    val = int'($urandom_range(0, 40)) - 20;
                    3:
                    begin
                        case ($urandom_range(0, 4))
                            0: val = 32'sh8000_0000;
                            1: val = 32'sh7FFF_FFFF;
                            2: val = -1;
                            3: val = 1;
                            default: val = 0;
                        endcase
                    end
                    default: val = int'($urandom_range(0, 200000)) - 100000;
                endcase
                case ($urandom_range(0, 19))
                    0:       fw = 7'd0;
                    1:       fw = 7'($urandom_range(65, 127));
                    2, 3:    fw = 7'($urandom_range(17, 64));
                    default: fw = 7'($urandom_range(1, 16));
                endcase
                case ($urandom_range(0, 9))
                    0:          md = 7'($urandom_range(0, 127));
                    1, 2, 3:    md = 7'd0;
                    default:    md = 7'($urandom_range(0, 12));
                endcase
                send_item(val, fw, md);
                sent++;
            end
            // Now and then the next burst follows with no gap at all.
            if ($urandom_range(0, 3) != 0)
            begin
                push = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
        end
    endtask

    // Receiver: pops on a pattern that changes every so often, and once, when
    // asked, holds off for a long stretch so that the block fills and raises full.
    initial
    begin : receiver
        int tick;
        int stall_style;

        tick        = 0;
        stall_style = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                pop        = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            tick++;
            if (tick % 150 == 0)
                stall_style = $urandom_range(0, 3);
            case (stall_style)
                0:       pop = 1'b1;
                1:       pop = ($urandom_range(0, 1) == 0);
                2:       pop = ($urandom_range(0, 3) == 0);
                default: pop = ((tick / 7) % 2 == 0);
            endcase
        end
    end

    initial
    begin : stimulus
        int phase;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed fields without the plus sign.
        write_plus_mode(1'b0);
        send_item(0, 7'd5, 7'd0);                   // zero with no minimum: blanks
        send_item(0, 7'd1, 7'd1);
        send_item(32'sh8000_0000, 7'd11, 7'd0);     // most negative value, full magnitude
        send_item(32'sh8000_0000, 7'd10, 7'd0);     // sign with no room
        send_item(32'sh7FFF_FFFF, 7'd10, 7'd0);
        send_item(32'sh7FFF_FFFF, 7'd9, 7'd0);      // digits do not fit
        send_item(123, 7'd0, 7'd0);                 // zero width emits nothing
        send_item(123, 7'd100, 7'd0);               // oversized width is clipped
        send_item(7, 7'd64, 7'd64);                 // minimum fills the whole field
        send_item(-7, 7'd64, 7'd64);                // same, but a sign is needed
        send_item(42, 7'd5, 7'd6);                  // minimum larger than the field
        send_item(42, 7'd8, 7'd5);
        send_item(-1, 7'd3, 7'd0);
        send_item(5, 7'd1, 7'd0);
        send_item(0, 7'd127, 7'd127);
        send_item(-5, 7'd127, 7'd0);
        send_item(0, 7'd4, 7'd2);
        send_item(32'sh5A5A_A5A5, 7'd12, 7'd0);
        drain_block();

        // Directed fields with the plus sign.
        write_plus_mode(1'b1);
        send_item(0, 7'd4, 7'd0);                   // blanks even with plus on
        send_item(0, 7'd2, 7'd1);
        send_item(9, 7'd1, 7'd0);                   // plus sign with no room
        send_item(32'sh7FFF_FFFF, 7'd11, 7'd0);
        send_item(-3, 7'd4, 7'd2);
        drain_block();

        // Random phases, alternating plus_mode; the long receiver hold falls in
        // one of them while the sender keeps offering fields.
        for (phase = 0; phase < PHASES; phase++)
        begin
            write_plus_mode(phase % 2 == 1);
            if (phase == 2)
                hold_request = 1'b1;
            random_items(PHASE_ITEMS);
            drain_block();
        end

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
